@@ hdl/qr_v4_data_module_placer_macros.svh @@
// Assertion macros shared by the QR version-4 data module placer.
// The macros expect signals named clk and rst in the module that uses them.
`ifndef QR_V4_DATA_MODULE_PLACER_MACROS_SVH
`define QR_V4_DATA_MODULE_PLACER_MACROS_SVH

// Condition must hold in the same cycle as the antecedent.
`define QR4P_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qr4p: same-cycle check failed");

// Condition must hold in the cycle after the antecedent.
`define QR4P_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qr4p: next-cycle check failed");

`endif

@@ hdl/qr4p_pkg.sv @@
// Shared types, constants and functions of the QR version-4 data module placer.
// Used by the controller, the datapath and the top level; depends on nothing.
package qr4p_pkg;

  // Symbol geometry.
  localparam int SIDE      = 33;
  localparam int POS_W     = 6;
  localparam int FINDER_SZ = 8;
  localparam int TIMING    = 6;
  localparam int ALIGN_LO  = SIDE - 9;
  localparam int ALIGN_HI  = SIDE - 5;
  localparam int PROD_W    = 2 * POS_W;

  // Configuration port.
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam int MASK_W    = 3;
  localparam logic REG_MASK = 1'b0;

  // Standard data mask numbers.
  typedef enum logic [MASK_W-1:0] {
    MASK_CHECKER = 3'd0,
    MASK_ROWS    = 3'd1,
    MASK_COLS3   = 3'd2,
    MASK_DIAG3   = 3'd3,
    MASK_BLOCKS  = 3'd4,
    MASK_PROD    = 3'd5,
    MASK_PROD2   = 3'd6,
    MASK_MIXED   = 3'd7
  } mask_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SKIP = 2'b10
  } state_t;

  // Placement cursor.
  typedef struct packed {
    logic [POS_W-1:0] pcol;
    logic             up;
    logic [POS_W-1:0] crow;
    logic             on_left;
  } cursor_t;

  // Cursor after one zigzag move.
  typedef struct packed {
    cursor_t cur;
    logic    ended;
  } step_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic step;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;
    logic overflow;
  } status_t;

  localparam cursor_t CURSOR_START = '{
    pcol: POS_W'(SIDE - 1), up: 1'b1, crow: POS_W'(SIDE - 1), on_left: 1'b0};

  // True for finders, separators, format area, timing, dark module, alignment.
  function automatic logic is_function(logic [POS_W-1:0] r, logic [POS_W-1:0] c);
    logic hit;
    hit = 1'b0;
    if (r <= POS_W'(FINDER_SZ) && c <= POS_W'(FINDER_SZ)) hit = 1'b1;
    if (r <= POS_W'(FINDER_SZ) && c >= POS_W'(SIDE - FINDER_SZ)) hit = 1'b1;
    if (r >= POS_W'(SIDE - FINDER_SZ) && c <= POS_W'(FINDER_SZ)) hit = 1'b1;
    if (r >= POS_W'(ALIGN_LO) && r <= POS_W'(ALIGN_HI) &&
        c >= POS_W'(ALIGN_LO) && c <= POS_W'(ALIGN_HI)) hit = 1'b1;
    if (r == POS_W'(TIMING) || c == POS_W'(TIMING)) hit = 1'b1;
    return hit;
  endfunction

  // Remainder by three: base-4 digits sum to the same residue.
  function automatic logic [1:0] mod3(logic [PROD_W-1:0] v);
    logic [4:0] s1;
    logic [2:0] s2;
    logic [2:0] s3;
    s1 = '0;
    for (int i = 0; i < PROD_W / 2; i++) begin
      s1 = s1 + 5'(v[2*i +: 2]);
    end
    s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
    s3 = 3'(s2[1:0]) + 3'(s2[2]);
    return (s3 >= 3'd3) ? 2'(s3 - 3'd3) : s3[1:0];
  endfunction

  // Standard mask condition at (r, c).
  function automatic logic mask_hit(logic [MASK_W-1:0] m, logic [POS_W-1:0] r,
                                    logic [POS_W-1:0] c);
    logic [PROD_W-1:0] p;
    logic [POS_W:0]    rc_sum;
    logic [PROD_W-1:0] c_mul;
    logic [POS_W:0]    q;
    logic [1:0]        p3;
    logic              hit;
    p      = PROD_W'(r) * PROD_W'(c);
    rc_sum = {1'b0, r} + {1'b0, c};
    // Division by three through the reciprocal 43/128, exact for six-bit values.
    c_mul  = PROD_W'(c) * PROD_W'(43);
    q      = (POS_W + 1)'(r >> 1) + (POS_W + 1)'(c_mul >> 7);
    p3     = mod3(p);
    case (mask_t'(m))
      MASK_CHECKER: hit = ~rc_sum[0];
      MASK_ROWS:    hit = ~r[0];
      MASK_COLS3:   hit = (mod3(PROD_W'(c)) == 2'd0);
      MASK_DIAG3:   hit = (mod3(PROD_W'(rc_sum)) == 2'd0);
      MASK_BLOCKS:  hit = ~q[0];
      MASK_PROD:    hit = ~p[0] && (p3 == 2'd0);
      MASK_PROD2:   hit = ~(p[0] ^ p3[0]);
      MASK_MIXED:   hit = ~(rc_sum[0] ^ p3[0]);
      default:      hit = 1'b0;
    endcase
    return hit;
  endfunction

  // One move along the two-column zigzag; column 6 is jumped over.
  function automatic step_t step_cursor(cursor_t c);
    step_t s;
    logic  at_edge;
    s.cur   = c;
    s.ended = 1'b0;
    if (!c.on_left) begin
      s.cur.on_left = 1'b1;
    end else begin
      s.cur.on_left = 1'b0;
      at_edge = c.up ? (c.crow == '0) : (c.crow >= POS_W'(SIDE - 1));
      if (at_edge) begin
        if (c.pcol <= POS_W'(1)) begin
          s.ended = 1'b1;
        end else begin
          s.cur.pcol = (c.pcol == POS_W'(FINDER_SZ)) ? POS_W'(TIMING - 1)
                                                      : c.pcol - POS_W'(2);
          s.cur.up   = ~c.up;
        end
      end else begin
        s.cur.crow = c.up ? c.crow - POS_W'(1) : c.crow + POS_W'(1);
      end
    end
    return s;
  endfunction

endpackage

@@ hdl/qr_v4_data_module_placer.sv @@
// Top level of the QR version-4 data module placer: register port and wiring.
// Depends on qr4p_pkg, qr4p_ctrl and qr4p_datapath.
//
// Usage:
// The input channel (in_valid, in_stall, data_bit, first_of_symbol) takes one
// codeword bit per request; first_of_symbol restarts placement at the bottom
// right corner of a new 33 by 33 symbol. The output channel (out_valid,
// out_stall, row, column, dark, last, overflow) returns one result per request.
// The mask number is written through the register port at byte address 0.
// After a request is taken, the result becomes valid once the cursor has moved
// on past every function module that follows the placed position; the step unit
// moves the cursor one position per cycle while it skips. Over a full symbol the
// cursor walks 1056 positions for 807 bits.
// Bits past the final free module come back with overflow set and no skip.
// The result sits in an output register; the next request is taken in the
// cycle the result leaves, and in_stall stays high while a skip runs or the
// held result is stalled.
// Reset clears the cursor to the bottom right corner, empties the output and
// sets mask number 0.

module qr_v4_data_module_placer import qr4p_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              data_bit,
  input  logic              first_of_symbol,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [POS_W-1:0]  row,
  output logic [POS_W-1:0]  column,
  output logic              dark,
  output logic              last,
  output logic              overflow
);

  logic [MASK_W-1:0] mask;
  logic              reg_write;
  ctrl_t             cmd;
  status_t           status;

  // Register port: no wait states; the word index sits above the byte offset.
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= MASK_W'(MASK_CHECKER);
    end else if (reg_write && paddr[2] == REG_MASK) begin
      mask <= pwdata[MASK_W-1:0];
    end
  end

  // Read back.
  always_comb begin
    unique case (paddr[2])
      REG_MASK: prdata = DATA_W'(mask);
      default:  prdata = '0;
    endcase
  end

  qr4p_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  qr4p_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .mask            (mask),
    .data_bit        (data_bit),
    .first_of_symbol (first_of_symbol),
    .status          (status),
    .row             (row),
    .column          (column),
    .dark            (dark),
    .last            (last),
    .overflow        (overflow)
  );

endmodule

@@ hdl/qr4p_ctrl.sv @@
// Controller of the QR version-4 data module placer: handshakes and skip sequencing.
// Depends on qr4p_pkg and the assertion macros header.
`include "qr_v4_data_module_placer_macros.svh"

module qr4p_ctrl import qr4p_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    out_stall,
  input  status_t status,
  output ctrl_t   cmd,
  output logic    in_stall,
  output logic    out_valid
);

  state_t state, state_next;
  logic   out_valid_next;
  logic   finish;

  // A request is taken when no skip is running and the result slot frees up.
  assign in_stall   = (state == ST_SKIP) || (out_valid && out_stall);
  assign cmd.accept = in_valid && !in_stall;
  assign cmd.step   = (state == ST_SKIP);

  // Next state and result-valid logic.
  always_comb begin
    state_next = state;
    finish     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (cmd.accept) begin
          if (status.overflow || status.done) begin
            finish = 1'b1;
          end else begin
            state_next = ST_SKIP;
          end
        end
      end
      ST_SKIP: begin
        if (status.done) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    out_valid_next = (out_valid && out_stall) || finish;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `QR4P_ASSERT_NOW(a_skip_no_result, state == ST_SKIP, !out_valid)
  `QR4P_ASSERT_NOW(a_skip_blocks_input, state == ST_SKIP, in_stall)
  `QR4P_ASSERT_NEXT(a_skip_done_shows, state == ST_SKIP && status.done, out_valid)
  `QR4P_ASSERT_NEXT(a_overflow_shows, cmd.accept && status.overflow,
                    out_valid && state == ST_IDLE)

endmodule

@@ hdl/qr4p_datapath.sv @@
// Datapath of the QR version-4 data module placer: cursor, step unit, mask, result.
// Depends on qr4p_pkg and the assertion macros header.
`include "qr_v4_data_module_placer_macros.svh"

module qr4p_datapath import qr4p_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  ctrl_t             cmd,
  input  logic [MASK_W-1:0] mask,
  input  logic              data_bit,
  input  logic              first_of_symbol,
  output status_t           status,
  output logic [POS_W-1:0]  row,
  output logic [POS_W-1:0]  column,
  output logic              dark,
  output logic              last,
  output logic              overflow
);

  cursor_t          cur;
  logic             full;
  cursor_t          base_cur;
  logic             base_full;
  logic [POS_W-1:0] base_col;
  step_t            st;
  logic [POS_W-1:0] st_col;

  // A new symbol restarts the cursor before the request is placed.
  always_comb begin
    if (cmd.accept && first_of_symbol) begin
      base_cur  = CURSOR_START;
      base_full = 1'b0;
    end else begin
      base_cur  = cur;
      base_full = full;
    end
    base_col = base_cur.pcol - POS_W'(base_cur.on_left);
    st       = step_cursor(base_cur);
    st_col   = st.cur.pcol - POS_W'(st.cur.on_left);
  end

  // The move is finished on a free module or past the final one.
  assign status.overflow = base_full;
  assign status.done     = st.ended || !is_function(st.cur.crow, st_col);

  // Cursor state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur  <= CURSOR_START;
      full <= 1'b0;
    end else if (cmd.accept && base_full) begin
      cur  <= base_cur;
    end else if (cmd.accept || cmd.step) begin
      cur  <= st.cur;
      full <= st.ended;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (base_full) begin
        row      <= '0;
        column   <= '0;
        dark     <= 1'b0;
        last     <= 1'b0;
        overflow <= 1'b1;
      end else begin
        row      <= base_cur.crow;
        column   <= base_col;
        dark     <= data_bit ^ mask_hit(mask, base_cur.crow, base_col);
        last     <= st.ended;
        overflow <= 1'b0;
      end
    end else if (cmd.step && st.ended) begin
      last <= 1'b1;
    end
  end

  `QR4P_ASSERT_NOW(a_row_in_range, 1'b1, cur.crow <= POS_W'(SIDE - 1))
  `QR4P_ASSERT_NOW(a_col_in_range, 1'b1, cur.pcol <= POS_W'(SIDE - 1))
  `QR4P_ASSERT_NEXT(a_cursor_holds, !cmd.accept && !cmd.step, $stable(cur))
  `QR4P_ASSERT_NOW(a_no_step_when_full, cmd.step, !full)

endmodule
